// ===== hw/rtl/agfc_pkg.sv =====
`timescale 1ns / 1ps
package agfc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int CW_W   = 13;
	localparam int ADDR_W = 24;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NEW   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FRAME = 2'd1;
	localparam logic [1:0] ST_OUTSIDE  = 2'd2;

	localparam logic [2:0] DISP_CLEAR   = 3'd2;
	localparam logic [2:0] DISP_RESTORE = 3'd3;

	localparam logic [19:0] DELAY_DEFAULT_MS = 20'd100;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] frame_left;
		logic [15:0] frame_top;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [2:0]  disposal_method;
		logic [15:0] delay_centi;
		logic [31:0] pixel_bgra;
		logic [7:0]  read_x;
		logic [7:0]  read_y;
	} in_t;

	typedef struct packed {
		logic [31:0] canvas_pixel;
		logic [19:0] delay_ms;
		logic        pixel_landed;
		logic [1:0]  status;
	} out_t;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_PIX   = 2'd1,
		OP_RD    = 2'd2,
		OP_NEW   = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              do_clear;
		logic              do_restore;
		logic              do_save;
		logic              landed;
		logic [1:0]        status;
		logic [CW_W-1:0]   x0;
		logic [CW_W-1:0]   x1;
		logic [CW_W-1:0]   y0;
		logic [CW_W-1:0]   y1;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       bgra;
		logic [19:0]       delay;
	} op_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

// ===== hw/rtl/agfc_front.sv =====
`timescale 1ns / 1ps
module agfc_front
	import agfc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       q_full,
	input  back_stat_t bstat,
	output logic       push,
	output op_t        push_op
);

	logic [8:0]  cfg_w_q, cfg_h_q;
	logic [15:0] left_q, top_q, wid_q, hgt_q;
	logic [2:0]  disp_q;
	logic [15:0] rx_q, ry_q;
	logic        open_q, saved_valid_q;

	logic [CW_W-1:0] cw_e, ch_e;
	logic [16:0] cw17, ch17, xs, ys, x0, x1, y0, y1, cx, cy, nx, ny;
	logic        clr_ok;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full | bstat.init_busy;
	assign push      = in_valid & ~in_stall;

	always_comb begin
		if (cfg_w_q == 9'd0) cw_e = CW_W'(1);
		else if (CW_W'(cfg_w_q) > CW_W'(MAX_WIDTH)) cw_e = CW_W'(MAX_WIDTH);
		else cw_e = CW_W'(cfg_w_q);
		if (cfg_h_q == 9'd0) ch_e = CW_W'(1);
		else if (CW_W'(cfg_h_q) > CW_W'(MAX_HEIGHT)) ch_e = CW_W'(MAX_HEIGHT);
		else ch_e = CW_W'(cfg_h_q);
	end

	always_comb begin
		cw17 = 17'(cw_e);
		ch17 = 17'(ch_e);
		xs = {1'b0, left_q} + {1'b0, wid_q};
		ys = {1'b0, top_q} + {1'b0, hgt_q};
		x0 = ({1'b0, left_q} < cw17) ? {1'b0, left_q} : cw17;
		x1 = (xs < cw17) ? xs : cw17;
		y0 = ({1'b0, top_q} < ch17) ? {1'b0, top_q} : ch17;
		y1 = (ys < ch17) ? ys : ch17;
		clr_ok = (x0 < x1) && (y0 < y1);
		cx = {1'b0, left_q} + {1'b0, rx_q};
		cy = {1'b0, top_q} + {1'b0, ry_q};
		nx = {1'b0, rx_q} + 17'd1;
		ny = {1'b0, ry_q} + 17'd1;
	end

	always_comb begin
		push_op = '0;
		unique case (in_item.command)
			CMD_BEGIN: begin
				push_op.kind       = OP_BEGIN;
				push_op.do_clear   = (disp_q == DISP_CLEAR) && clr_ok;
				push_op.do_restore = (disp_q == DISP_RESTORE) && saved_valid_q;
				// a restore leaves canvas equal to the saved copy already
				push_op.do_save    = (in_item.disposal_method == DISP_RESTORE) &&
					!push_op.do_restore;
				push_op.x0 = CW_W'(x0);
				push_op.x1 = CW_W'(x1);
				push_op.y0 = CW_W'(y0);
				push_op.y1 = CW_W'(y1);
				if (in_item.delay_centi == 16'd0) push_op.delay = DELAY_DEFAULT_MS;
				else push_op.delay = (20'(in_item.delay_centi) << 3) +
					(20'(in_item.delay_centi) << 1);
			end
			CMD_PIXEL: begin
				push_op.kind = OP_PIX;
				push_op.bgra = in_item.pixel_bgra;
				if (!open_q) begin
					push_op.status = ST_NO_FRAME;
				end else begin
					push_op.landed = (cx < cw17) && (cy < ch17);
					push_op.addr = ADDR_W'(cy[CW_W-1:0]) * ADDR_W'(MAX_WIDTH) +
						ADDR_W'(cx[CW_W-1:0]);
				end
			end
			CMD_READ: begin
				push_op.kind = OP_RD;
				if (CW_W'(in_item.read_x) < cw_e && CW_W'(in_item.read_y) < ch_e)
					push_op.status = ST_OK;
				else
					push_op.status = ST_OUTSIDE;
				push_op.addr = ADDR_W'(in_item.read_y) * ADDR_W'(MAX_WIDTH) +
					ADDR_W'(in_item.read_x);
			end
			default: begin
				push_op.kind = OP_NEW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 9'd256;
			cfg_h_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH:  cfg_w_q <= cfg_data;
				CFG_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0; top_q <= '0; wid_q <= '0; hgt_q <= '0;
			disp_q <= '0; rx_q <= '0; ry_q <= '0;
			open_q <= 1'b0; saved_valid_q <= 1'b0;
		end else if (push) begin
			unique case (in_item.command)
				CMD_BEGIN: begin
					saved_valid_q <= in_item.disposal_method == DISP_RESTORE;
					left_q <= in_item.frame_left;
					top_q  <= in_item.frame_top;
					wid_q  <= in_item.frame_width;
					hgt_q  <= in_item.frame_height;
					disp_q <= in_item.disposal_method;
					rx_q <= '0;
					ry_q <= '0;
					open_q <= (in_item.frame_width != 16'd0) &&
						(in_item.frame_height != 16'd0);
				end
				CMD_PIXEL: begin
					if (open_q) begin
						if (nx >= {1'b0, wid_q}) begin
							rx_q <= '0;
							if (ny >= {1'b0, hgt_q}) begin
								ry_q <= '0;
								open_q <= 1'b0;
							end else begin
								ry_q <= ny[15:0];
							end
						end else begin
							rx_q <= nx[15:0];
						end
					end
				end
				CMD_READ: ;
				default: begin
					left_q <= '0; top_q <= '0; wid_q <= '0; hgt_q <= '0;
					disp_q <= '0; rx_q <= '0; ry_q <= '0;
					open_q <= 1'b0; saved_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/agfc_queue.sv =====
`timescale 1ns / 1ps
module agfc_queue
	import agfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic empty,
	output op_t  head
);

	op_t        ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hw/rtl/agfc_back.sv =====
`timescale 1ns / 1ps
module agfc_back
	import agfc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  op_t        head,
	output logic       pop,
	output back_stat_t bstat,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_item
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CLR  = 6'b000010,
		S_RST  = 6'b000100,
		S_SAV  = 6'b001000,
		S_PIX  = 6'b010000,
		S_RD   = 6'b100000
	} state_t;

	logic [31:0] canvas [DEPTH];
	logic [31:0] saved [DEPTH];

	state_t          state_q;
	op_t             op_q;
	logic            init_q, out_pend_q, rest_pend_q, save_pend_q;
	logic [CW_W-1:0] x_q, y_q, x0_q, x1_q, y1_q;
	logic [AW-1:0]   cnt_q, cp_a_q;
	logic            iss_done_q, cp_v_q;
	logic [31:0]     cv_rd_q, sv_rd_q;
	logic            out_valid_q;
	out_t            out_q;

	logic          cv_we, sv_we, set_out, out_free, clr_last, copy_fin;
	logic [AW-1:0] cv_wa, cv_ra;
	logic [31:0]   cv_wd, res_pix;
	logic [ADDR_W-1:0] clr_addr;
	op_t           res_op;

	function automatic logic [31:0] blend(input logic [31:0] src, input logic [31:0] dst);
		logic [7:0]  inv;
		logic [15:0] p;
		logic [16:0] q;
		logic [31:0] r;
		inv = 8'd255 - src[31:24];
		r = '0;
		if (src[31:24] == 8'd255) begin
			r = src;
		end else if (src[31:24] == 8'd0) begin
			r = dst;
		end else begin
			for (int k = 0; k < 4; k++) begin
				p = 16'(dst[8*k +: 8]) * 16'(inv);
				// floor divide by 255, exact for products below 255 * 255
				q = 17'(p) + 17'(p[15:8]) + 17'd1;
				r[8*k +: 8] = src[8*k +: 8] + q[15:8];
			end
		end
		return r;
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && !q_empty && out_free;
	assign bstat.init_busy = init_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign clr_addr = ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
	assign clr_last = (x_q == x1_q - 1'b1) && (y_q == y1_q - 1'b1);
	assign copy_fin = iss_done_q && !cp_v_q;

	always_comb begin
		cv_we = 1'b0;
		cv_wa = cp_a_q;
		cv_wd = sv_rd_q;
		unique case (state_q)
			S_CLR: begin
				cv_we = 1'b1;
				cv_wa = clr_addr[AW-1:0];
				cv_wd = '0;
			end
			S_RST: cv_we = cp_v_q;
			S_PIX: begin
				cv_we = 1'b1;
				cv_wa = op_q.addr[AW-1:0];
				cv_wd = blend(op_q.bgra, cv_rd_q);
			end
			default: ;
		endcase
		sv_we = (state_q == S_SAV) && cp_v_q;
		cv_ra = (state_q == S_SAV) ? cnt_q : head.addr[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cv_we) canvas[cv_wa] <= cv_wd;
		cv_rd_q <= canvas[cv_ra];
	end

	always_ff @(posedge clk) begin
		if (sv_we) saved[cp_a_q] <= cv_rd_q;
		sv_rd_q <= saved[cnt_q];
	end

	// result of the item that completes this cycle
	always_comb begin
		set_out = 1'b0;
		res_op  = op_q;
		res_pix = '0;
		priority case (1'b1)
			pop: begin
				res_op = head;
				unique case (head.kind)
					OP_BEGIN: set_out = !head.do_clear && !head.do_restore && !head.do_save;
					OP_PIX:   set_out = !head.landed;
					OP_RD:    set_out = head.status != ST_OK;
					default:  set_out = 1'b0;
				endcase
			end
			state_q == S_CLR: set_out = clr_last && out_pend_q && !rest_pend_q && !save_pend_q;
			state_q == S_RST: set_out = copy_fin && out_pend_q && !save_pend_q;
			state_q == S_SAV: set_out = copy_fin && out_pend_q;
			state_q == S_PIX: set_out = 1'b1;
			state_q == S_RD: begin
				set_out = 1'b1;
				res_pix = cv_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (set_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_out) begin
			out_q.canvas_pixel <= res_pix;
			out_q.delay_ms     <= res_op.delay;
			out_q.pixel_landed <= res_op.landed;
			out_q.status       <= res_op.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			init_q <= 1'b1;
			out_pend_q <= 1'b0;
			rest_pend_q <= 1'b0;
			save_pend_q <= 1'b0;
			x_q <= '0; y_q <= '0; x0_q <= '0;
			x1_q <= CW_W'(MAX_WIDTH);
			y1_q <= CW_W'(MAX_HEIGHT);
			cnt_q <= '0; cp_a_q <= '0;
			iss_done_q <= 1'b0; cp_v_q <= 1'b0;
			op_q <= '0;
		end else begin
			cp_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					iss_done_q <= 1'b0;
					if (pop) begin
						op_q <= head;
						rest_pend_q <= head.do_restore;
						save_pend_q <= head.do_save;
						out_pend_q <= 1'b1;
						unique case (head.kind)
							OP_BEGIN: begin
								x_q <= head.x0; y_q <= head.y0;
								x0_q <= head.x0; x1_q <= head.x1; y1_q <= head.y1;
								if (head.do_clear) state_q <= S_CLR;
								else if (head.do_restore) state_q <= S_RST;
								else if (head.do_save) state_q <= S_SAV;
							end
							OP_PIX: if (head.landed) state_q <= S_PIX;
							OP_RD:  if (head.status == ST_OK) state_q <= S_RD;
							default: begin
								rest_pend_q <= 1'b0;
								save_pend_q <= 1'b0;
								x_q <= '0; y_q <= '0; x0_q <= '0;
								x1_q <= CW_W'(MAX_WIDTH);
								y1_q <= CW_W'(MAX_HEIGHT);
								state_q <= S_CLR;
							end
						endcase
					end
				end
				S_CLR: begin
					if (clr_last) begin
						init_q <= 1'b0;
						if (rest_pend_q) state_q <= S_RST;
						else if (save_pend_q) state_q <= S_SAV;
						else state_q <= S_IDLE;
					end else if (x_q == x1_q - 1'b1) begin
						x_q <= x0_q;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				S_RST, S_SAV: begin
					if (!iss_done_q) begin
						cp_v_q <= 1'b1;
						cp_a_q <= cnt_q;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == AW'(DEPTH - 1)) iss_done_q <= 1'b1;
					end else if (copy_fin) begin
						cnt_q <= '0;
						iss_done_q <= 1'b0;
						if (state_q == S_RST && save_pend_q) state_q <= S_SAV;
						else state_q <= S_IDLE;
					end
				end
				S_PIX: state_q <= S_IDLE;
				S_RD:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE) && !init_q)
		else $error("queue pop while busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		set_out |-> out_free)
		else $error("result overwrites an untaken result");
	a_clr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> (x_q < x1_q) && (y_q < y1_q))
		else $error("clear walk out of rectangle");
	a_init_silent: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !set_out)
		else $error("result during reset clearing pass");
`endif

endmodule

// ===== hw/rtl/animated_gif_frame_compositor.sv =====
`timescale 1ns / 1ps
// Frame compositor for animated images onto a MAX_WIDTH x MAX_HEIGHT canvas.
// Input channel (in_valid/in_stall/in_item) carries commands: frame_begin,
// frame pixel, canvas read, new_animation. Each command yields exactly one
// result on the output channel (out_valid/out_stall/out_item).
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets canvas width
// (index 0) and height (index 1); write only while the block is idle.
// The front classifies each command, clips rectangles and tracks the raster;
// a two-entry queue decouples it from the back, which owns canvas memories.
// Unlanded pixels and bad reads give their result as they are popped; landed
// pixels and good reads go through S_PIX or S_RD first (single canvas read
// port, read then write). frame_begin walks the clipped rectangle, clearing
// one pixel at a time, or copies the whole canvas for each restore or save.
// new_animation clears the whole canvas. After reset the canvas is cleared
// with in_stall high. A stalled result holds in the output register; the
// queue keeps accepting until full, then in_stall rises.
module animated_gif_frame_compositor
	import agfc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	logic       push, pop, q_full, q_empty;
	op_t        push_op, head;
	back_stat_t bstat;

	agfc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_full(q_full), .bstat(bstat), .push(push), .push_op(push_op)
	);

	agfc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_op(push_op), .pop(pop),
		.full(q_full), .empty(q_empty), .head(head)
	);

	agfc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .head(head), .pop(pop), .bstat(bstat),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

endmodule

// ===== sim/animated_gif_frame_compositor_tb.sv =====
`timescale 1ns / 1ps
module animated_gif_frame_compositor_tb;
	import agfc_pkg::*;

	localparam int MAXW = DEF_MAX_WIDTH;
	localparam int MAXH = DEF_MAX_HEIGHT;
	localparam int WORDS = MAXW * MAXH;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_t        in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_WIDTH;
	logic [8:0] cfg_data = '0;

	animated_gif_frame_compositor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Canvas model
	logic [31:0] canvas [WORDS];
	logic [31:0] saved_canvas [WORDS];
	bit          saved_ok;
	logic [2:0]  cur_disp;
	int unsigned cur_left, cur_top, cur_w, cur_h;
	int unsigned scan_x, scan_y;
	bit          open_frame;
	logic [8:0]  width_reg = 9'd256, height_reg = 9'd256;

	out_t        pending_q[$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle = 0, recv_stall = 0;
	int          copy_budget, wipe_budget;

	function automatic int unsigned eff_dim(logic [8:0] v, int unsigned maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic logic [31:0] blend_over(logic [31:0] src, logic [31:0] dst);
		logic [31:0] res;
		int unsigned inv;
		res = '0;
		if (src[31:24] == 8'hff) return src;
		if (src[31:24] == 8'h00) return dst;
		inv = 255 - src[31:24];
		for (int sh = 0; sh < 32; sh += 8)
			res[sh +: 8] = 8'(src[sh +: 8] + (dst[sh +: 8] * inv) / 255);
		return res;
	endfunction

	task automatic wipe_canvas();
		foreach (canvas[i]) canvas[i] = '0;
		saved_ok = 0;
		cur_disp = '0;
		cur_left = 0; cur_top = 0; cur_w = 0; cur_h = 0;
		scan_x = 0; scan_y = 0;
		open_frame = 0;
	endtask

	task automatic composite(input in_t it, output out_t res);
		int unsigned cw, ch, x0, x1, y0, y1, cx, cy;
		cw = eff_dim(width_reg, MAXW);
		ch = eff_dim(height_reg, MAXH);
		res = '0;
		case (it.command)
			CMD_BEGIN: begin
				if (cur_disp == DISP_CLEAR) begin
					x0 = (cur_left < cw) ? cur_left : cw;
					x1 = (cur_left + cur_w < cw) ? cur_left + cur_w : cw;
					y0 = (cur_top < ch) ? cur_top : ch;
					y1 = (cur_top + cur_h < ch) ? cur_top + cur_h : ch;
					for (int unsigned y = y0; y < y1; y++)
						for (int unsigned x = x0; x < x1; x++)
							canvas[y * MAXW + x] = '0;
				end else if (cur_disp == DISP_RESTORE && saved_ok) begin
					canvas = saved_canvas;
				end
				if (it.disposal_method == DISP_RESTORE) begin
					saved_canvas = canvas;
					saved_ok = 1;
				end else begin
					saved_ok = 0;
				end
				cur_left = 32'(it.frame_left);
				cur_top = 32'(it.frame_top);
				cur_w = 32'(it.frame_width);
				cur_h = 32'(it.frame_height);
				cur_disp = it.disposal_method;
				scan_x = 0;
				scan_y = 0;
				open_frame = (cur_w != 0) && (cur_h != 0);
				res.delay_ms = (it.delay_centi == 0) ? DELAY_DEFAULT_MS :
					20'(it.delay_centi * 10);
			end
			CMD_PIXEL: begin
				if (!open_frame) begin
					res.status = ST_NO_FRAME;
				end else begin
					cx = cur_left + scan_x;
					cy = cur_top + scan_y;
					if (cx < cw && cy < ch) begin
						canvas[cy * MAXW + cx] = blend_over(it.pixel_bgra, canvas[cy * MAXW + cx]);
						res.pixel_landed = 1'b1;
					end
					scan_x++;
					if (scan_x >= cur_w) begin
						scan_x = 0;
						scan_y++;
						if (scan_y >= cur_h) begin
							scan_y = 0;
							open_frame = 0;
						end
					end
				end
			end
			CMD_READ: begin
				if (it.read_x < cw && it.read_y < ch)
					res.canvas_pixel = canvas[it.read_y * MAXW + it.read_x];
				else
					res.status = ST_OUTSIDE;
			end
			default: wipe_canvas();
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** animated_gif_frame_compositor: FAILED **");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n) out_stall <= ($urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", out_item.canvas_pixel, '0);
			end else begin
				want = pending_q.pop_front();
				if (out_item.canvas_pixel !== want.canvas_pixel)
					report_mismatch("canvas_pixel", out_item.canvas_pixel, want.canvas_pixel);
				if (out_item.delay_ms !== want.delay_ms)
					report_mismatch("delay_ms", 32'(out_item.delay_ms),
						32'(want.delay_ms));
				if (out_item.pixel_landed !== want.pixel_landed)
					report_mismatch("pixel_landed", 32'(out_item.pixel_landed),
						32'(want.pixel_landed));
				if (out_item.status !== want.status)
					report_mismatch("status", 32'(out_item.status), 32'(want.status));
			end
		end
	end

	task automatic send_item(input in_t it);
		out_t res;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		composite(it, res);
		pending_q = {pending_q, res};
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned val);
		logic [8:0] v;
		v = 9'(val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH) width_reg = v;
		else height_reg = v;
		@(posedge clk);
	endtask

	function automatic in_t noise_item();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[$bits(in_t)-1:0];
	endfunction

	function automatic in_t begin_cmd(int unsigned l, int unsigned t, int unsigned w,
			int unsigned h, logic [2:0] d, int unsigned dl);
		in_t it;
		it = noise_item();
		it.command = CMD_BEGIN;
		it.frame_left = 16'(l); it.frame_top = 16'(t);
		it.frame_width = 16'(w); it.frame_height = 16'(h);
		it.disposal_method = d;
		it.delay_centi = 16'(dl);
		return it;
	endfunction

	function automatic in_t pixel_cmd(logic [31:0] p);
		in_t it;
		it = noise_item();
		it.command = CMD_PIXEL;
		it.pixel_bgra = p;
		return it;
	endfunction

	function automatic in_t read_cmd(int unsigned x, int unsigned y);
		in_t it;
		it = noise_item();
		it.command = CMD_READ;
		it.read_x = 8'(x); it.read_y = 8'(y);
		return it;
	endfunction

	task automatic test_directed();
		in_t it;
		write_reg(CFG_WIDTH, 8);
		write_reg(CFG_HEIGHT, 6);
		send_item(read_cmd(0, 0));
		send_item(read_cmd(9, 2));
		send_item(pixel_cmd(32'hff123456));
		send_item(begin_cmd(0, 0, 2, 2, DISP_CLEAR, 0));
		send_item(pixel_cmd(32'hff102030));
		send_item(pixel_cmd(32'h00ffffff));
		send_item(pixel_cmd(32'h80402010));
		send_item(pixel_cmd(32'h01ffffff));
		send_item(pixel_cmd(32'hfe000000));
		send_item(read_cmd(0, 0));
		send_item(read_cmd(1, 1));
		// clears the first frame, then saves for restore
		send_item(begin_cmd(6, 4, 3, 1, DISP_RESTORE, 65535));
		send_item(pixel_cmd(32'hffaaaaaa));
		send_item(pixel_cmd(32'hffbbbbbb));
		send_item(pixel_cmd(32'hffcccccc));
		send_item(read_cmd(7, 4));
		// zero-sized frame restores the saved canvas and opens nothing
		send_item(begin_cmd(0, 0, 0, 5, 3'd0, 1));
		send_item(pixel_cmd(32'hffffffff));
		send_item(read_cmd(7, 4));
		send_item(begin_cmd(65535, 65535, 65535, 65535, 3'd7, 7));
		send_item(pixel_cmd(32'hffffffff));
		send_item(begin_cmd(1, 1, 2, 2, DISP_CLEAR, 5));
		send_item(pixel_cmd(32'hff0000ff));
		it = noise_item();
		it.command = CMD_NEW;
		send_item(it);
		send_item(read_cmd(0, 0));
		wait_idle();
	endtask

	task automatic pick_canvas();
		case ($urandom_range(5))
			0: begin write_reg(CFG_WIDTH, 0); write_reg(CFG_HEIGHT, 511); end
			1: begin write_reg(CFG_WIDTH, 256); write_reg(CFG_HEIGHT, 256); end
			2: begin write_reg(CFG_WIDTH, 1); write_reg(CFG_HEIGHT, 1); end
			3: begin write_reg(CFG_WIDTH, $urandom); write_reg(CFG_HEIGHT, $urandom); end
			default: begin
				write_reg(CFG_WIDTH, $urandom_range(2, 16));
				write_reg(CFG_HEIGHT, $urandom_range(2, 16));
			end
		endcase
	endtask

	task automatic test_random(input int n, input bit pause_mid);
		int sent, npix, w, h, cw, ch;
		logic [2:0] d;
		in_t it;
		sent = 0;
		while (sent < n) begin
			cw = eff_dim(width_reg, MAXW);
			ch = eff_dim(height_reg, MAXH);
			if (pause_mid && sent > n / 2) begin
				wait_idle();
				pause_mid = 0;
			end
			if ($urandom_range(99) < 70) begin
				d = 3'($urandom_range(7));
				if (d == DISP_RESTORE) begin
					if (copy_budget > 0) copy_budget--;
					else d = DISP_CLEAR;
				end
				if ($urandom_range(99) < 8) begin
					it = begin_cmd($urandom, $urandom, $urandom, $urandom, d, $urandom);
					npix = $urandom_range(0, 12);
				end else begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 4);
					it = begin_cmd($urandom_range(0, cw + 1), $urandom_range(0, ch + 1),
						w, h, d, $urandom);
					npix = w * h + $urandom_range(0, 2) - 1;
				end
				send_item(it);
				sent++;
				for (int i = 0; i < npix; i++) begin
					if ($urandom_range(99) < 15)
						send_item(read_cmd($urandom_range(0, cw), $urandom_range(0, ch)));
					else
						send_item(pixel_cmd({$urandom_range(0, 3) == 0 ? 8'hff :
							($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom)), 24'($urandom)}));
					sent++;
				end
			end else if ($urandom_range(99) < 3 && wipe_budget > 0) begin
				wipe_budget--;
				it = noise_item();
				it.command = CMD_NEW;
				send_item(it);
				sent++;
			end else begin
				it = noise_item();
				it.command = $urandom_range(1, 2) == 1 ? CMD_PIXEL : CMD_READ;
				send_item(it);
				sent++;
			end
		end
		wait_idle();
	endtask

	task automatic test_no_idle();
		send_idle = 0; recv_stall = 0;
		pick_canvas();
		test_random(500, 1'b0);
	endtask

	task automatic test_sender_idle();
		send_idle = 45; recv_stall = 0;
		pick_canvas();
		test_random(500, 1'b1);
	endtask

	task automatic test_receiver_stall();
		send_idle = 0; recv_stall = 45;
		pick_canvas();
		test_random(500, 1'b0);
	endtask

	task automatic test_both_idle();
		send_idle = 23; recv_stall = 23;
		write_reg(CFG_WIDTH, 256);
		write_reg(CFG_HEIGHT, 256);
		test_random(500, 1'b0);
	endtask

	initial begin
		copy_budget = 2;
		wipe_budget = 2;
		wipe_canvas();
		foreach (saved_canvas[i]) saved_canvas[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		if (errors == 0 && pending_q.size() == 0) begin
			$display("** animated_gif_frame_compositor: PASSED **");
		end else begin
			$display("** animated_gif_frame_compositor: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/agfc_pkg.sv
hw/rtl/agfc_front.sv
hw/rtl/agfc_queue.sv
hw/rtl/agfc_back.sv
hw/rtl/animated_gif_frame_compositor.sv
sim/animated_gif_frame_compositor_tb.sv
